// ===== rtl/utf16_to_utf8_transcoder_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shared concurrent assertion wrappers used by the transcoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("u16u8 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("u16u8 assertion failed");

`endif

// ===== rtl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Widths, codes and shared types of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int CMP_W       = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // One sequence of 1 to 4 bytes, or a single terminator/status beat.
    typedef struct packed {
        logic [3:0][7:0]         bytes;
        logic [1:0]              last;
        logic [OFFSET_BITS-1:0]  base;
        logic                    byte_valid;
        logic                    eos;
        logic [1:0]              status;
    } seq_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, checks fit and emits sequence entries.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module u16u8_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,
    input  u16u8_pkg::queue_status_t q_status,
    output logic                     push,
    output u16u8_pkg::seq_entry_t    push_entry
);

    logic [15:0]                         cap_reg;
    logic [9:0]                          held_reg, held_next;
    logic                                high_pending_reg, high_pending_next;
    logic [u16u8_pkg::OFFSET_BITS-1:0]   off_reg, off_next;
    logic                                dropping_reg, dropping_next;

    logic        accept;
    logic [15:0] unit;
    logic        is_low, is_high;
    logic        take_high;
    logic [20:0] cp;
    logic [3:0][7:0] enc_bytes;
    logic [1:0]  enc_last;
    logic [2:0]  enc_len;
    logic [u16u8_pkg::CMP_W-1:0] end_pos, cap_m1;
    logic        fits;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign unit     = s_tdata;
    assign is_low   = (unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
    assign is_high  = (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    assign take_high = accept && is_high && !high_pending_reg && !dropping_reg &&
                       (cap_reg != 16'd0);

    // Pair value is 0x10000 + (held << 10) + low ten bits.
    assign cp = high_pending_reg ? (21'h10000 + {1'b0, held_reg, unit[9:0]})
                                 : {5'd0, unit};

    always_comb begin
        enc_bytes = '0;
        if (cp < 21'h80) begin
            enc_bytes[0] = cp[7:0];
            enc_last     = 2'd0;
        end else if (cp < 21'h800) begin
            enc_bytes[0] = {3'b110, cp[10:6]};
            enc_bytes[1] = {2'b10, cp[5:0]};
            enc_last     = 2'd1;
        end else if (cp < 21'h10000) begin
            enc_bytes[0] = {4'b1110, cp[15:12]};
            enc_bytes[1] = {2'b10, cp[11:6]};
            enc_bytes[2] = {2'b10, cp[5:0]};
            enc_last     = 2'd2;
        end else begin
            enc_bytes[0] = {5'b11110, cp[20:18]};
            enc_bytes[1] = {2'b10, cp[17:12]};
            enc_bytes[2] = {2'b10, cp[11:6]};
            enc_bytes[3] = {2'b10, cp[5:0]};
            enc_last     = 2'd3;
        end
    end

    assign enc_len = {1'b0, enc_last} + 3'd1;
    assign end_pos = u16u8_pkg::CMP_W'(off_reg) + u16u8_pkg::CMP_W'(enc_len);
    assign cap_m1  = u16u8_pkg::CMP_W'(cap_reg) - u16u8_pkg::CMP_W'(1);
    assign fits    = (end_pos <= cap_m1);

    always_comb begin
        held_next         = held_reg;
        high_pending_next = high_pending_reg;
        off_next          = off_reg;
        dropping_next     = dropping_reg;
        push              = 1'b0;
        push_entry        = '0;
        push_entry.base   = off_reg;
        push_entry.byte_valid = 1'b1;
        push_entry.status = u16u8_pkg::ST_OK;

        if (accept) begin
            if (dropping_reg) begin
                if (unit == 16'd0) begin
                    dropping_next = 1'b0;
                end
            end else if (cap_reg == 16'd0) begin
                push                  = 1'b1;
                push_entry.byte_valid = 1'b0;
                push_entry.base       = '0;
                push_entry.eos        = 1'b1;
                push_entry.status     = u16u8_pkg::ST_INVALID;
                held_next             = '0;
                high_pending_next     = 1'b0;
                off_next              = '0;
                dropping_next         = (unit != 16'd0);
            end else if ((high_pending_reg && is_low) ||
                         (!high_pending_reg && unit != 16'd0 && !is_high)) begin
                held_next         = '0;
                high_pending_next = 1'b0;
                push              = 1'b1;
                if (fits) begin
                    push_entry.bytes = enc_bytes;
                    push_entry.last  = enc_last;
                    off_next         = off_reg + u16u8_pkg::OFFSET_BITS'(enc_len);
                end else begin
                    // Terminator only, then drop the rest of the string.
                    push_entry.eos    = 1'b1;
                    push_entry.status = u16u8_pkg::ST_OVERFLOW;
                    off_next          = '0;
                    dropping_next     = 1'b1;
                end
            end else if (!high_pending_reg && is_high) begin
                held_next         = unit[9:0];
                high_pending_next = 1'b1;
            end else begin
                // Zero unit, or broken pair: terminate with status ok.
                push              = 1'b1;
                push_entry.eos    = 1'b1;
                held_next         = '0;
                high_pending_next = 1'b0;
                off_next          = '0;
                dropping_next     = (unit != 16'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg          <= u16u8_pkg::CAP_RESET;
            held_reg         <= '0;
            high_pending_reg <= 1'b0;
            off_reg          <= '0;
            dropping_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            held_reg         <= held_next;
            high_pending_reg <= high_pending_next;
            off_reg          <= off_next;
            dropping_reg     <= dropping_next;
        end
    end

    `U16U8_ASSERT(a_drop_no_hold, aclk, aresetn, dropping_reg, !high_pending_reg)
    `U16U8_ASSERT_NEXT(a_high_held, aclk, aresetn, take_high, high_pending_reg)

endmodule

// ===== rtl/u16u8_queue.sv =====
// ----------------------------------------------------------------------------
// u16u8_queue
// Small register FIFO of sequence entries between front and back.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module u16u8_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  u16u8_pkg::seq_entry_t    push_entry,
    input  logic                     pop,
    output u16u8_pkg::seq_entry_t    head,
    output u16u8_pkg::queue_status_t q_status
);

    u16u8_pkg::seq_entry_t               slots [u16u8_pkg::QUEUE_DEPTH];
    logic [u16u8_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [u16u8_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                                do_push, do_pop;
    logic                                count_ok;

    assign q_status.full  = (count_reg == u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = slots[rd_ptr_reg];
    assign count_ok       = (count_reg <= u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + u16u8_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - u16u8_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + u16u8_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + u16u8_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `U16U8_ASSERT(a_count_bound, aclk, aresetn, 1'b1, count_ok)

endmodule

// ===== rtl/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head entry one byte per beat and drives the result stream.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module u16u8_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  u16u8_pkg::seq_entry_t    head,
    input  u16u8_pkg::queue_status_t q_status,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,  // out_byte[7:0], byte_offset[23:8]
    output logic [2:0]               m_tuser,  // byte_valid[0], status[2:1]
    output logic                     m_tlast   // end_of_string
);

    logic [1:0]                          idx_reg, idx_next;
    logic                                beat;
    logic                                last_byte;
    logic [u16u8_pkg::OFFSET_BITS-1:0]   pos;
    logic [u16u8_pkg::CMP_W-1:0]         pos_wide;

    assign m_tvalid  = !q_status.empty;
    assign beat      = m_tvalid && m_tready;
    assign last_byte = (idx_reg == head.last);
    assign pop       = beat && last_byte;

    assign pos      = head.base + u16u8_pkg::OFFSET_BITS'(idx_reg);
    assign pos_wide = u16u8_pkg::CMP_W'(pos);

    assign m_tdata = {pos_wide[15:0], head.bytes[idx_reg]};
    assign m_tuser = {head.status, head.byte_valid};
    assign m_tlast = head.eos;

    always_comb begin
        idx_next = idx_reg;
        if (beat) begin
            idx_next = last_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    `U16U8_ASSERT(a_idx_in_seq, aclk, aresetn, m_tvalid, idx_reg <= head.last)
    `U16U8_ASSERT_NEXT(a_idx_rewind, aclk, aresetn, beat && m_tlast, idx_reg == 2'd0)

endmodule

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// An accepted code unit is encoded, then registered in the sequence queue that feeds m_.
// Throughput: one code unit per cycle on s_ unless the queue is full; the byte stream
// carries one byte per cycle while m_tready is high; an n-byte sequence takes n beats.
// A four-entry sequence queue lets the input side run ahead while results wait.
// Reset: synchronous active-low aresetn clears surrogate, offset and drop state,
// empties the queue and sets buffer_capacity to 65535.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Streams UTF-16 code units in and UTF-8 bytes with buffer offsets out.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,   // buffer_capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // code_unit[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // out_byte[7:0], byte_offset[23:8]
    output logic [2:0]  m_tuser,     // byte_valid[0], status[2:1]
    output logic        m_tlast      // end_of_string
);

    logic                     push;
    logic                     pop;
    u16u8_pkg::seq_entry_t    push_entry;
    u16u8_pkg::seq_entry_t    head;
    u16u8_pkg::queue_status_t q_status;

    u16u8_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    u16u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    u16u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
